// File: rtl/core/crpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpg_pkg
// Shared constants, types and command codes of the color ramp palette
// generator.
// ----------------------------------------------------------------------------
package crpg_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_BITS    = $clog2(PAL_ENTRIES);

    localparam int X_W     = 10;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 4;
    localparam int COLOR_W = NUM_CH * CH_W;
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CH_IDX_W = $clog2(NUM_CH);

    // Segment denominator dist * PAL_ENTRIES and the interpolation weights.
    localparam int W_W   = X_W + PAL_BITS;
    // Weighted channel sum, never above CH max times the denominator.
    localparam int ACC_W = CH_W + W_W;

    localparam int S_TDATA_W = ((X_W + COLOR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PAL_BITS + COLOR_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef logic [NUM_CH-1:0][CH_W-1:0] rgba_t;

    typedef struct packed {
        rgba_t          color;
        logic [X_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        point_t           point;
    } ptab_wr_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [W_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PAL_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [PAL_BITS-1:0] index;
        rgba_t               rgba;
        logic                last;
        logic                empty;
    } res_t;

endpackage

// File: rtl/core/crpg_ptab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpg_ptab
// Control point table: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module crpg_ptab
    import crpg_pkg::*;
(
    input  logic             aclk,
    input  ptab_wr_t         wr,
    input  logic [IDX_W-1:0] rd_addr_a,
    input  logic [IDX_W-1:0] rd_addr_b,
    output point_t           rd_data_a,
    output point_t           rd_data_b
);

    point_t mem [MAX_POINTS];
    point_t rd_a_reg;
    point_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.point;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: rtl/core/crpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpg_div
// Shared restoring divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in PAL_BITS bits.
// ----------------------------------------------------------------------------
module crpg_div
    import crpg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(PAL_BITS + 1);

    logic [W_W-1:0]      rem_reg,  rem_next;
    logic [PAL_BITS-1:0] low_reg,  low_next;
    logic [PAL_BITS-1:0] quo_reg,  quo_next;
    logic [W_W-1:0]      dsr_reg,  dsr_next;
    logic [STEP_W-1:0]   cnt_reg,  cnt_next;
    logic                done_reg, done_next;

    logic [W_W:0] trial;
    logic         fits;

    assign trial = {rem_reg, low_reg[PAL_BITS-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            // The upper part of the dividend is below the divisor.
            rem_next = req.dividend[ACC_W-1:PAL_BITS];
            low_next = req.dividend[PAL_BITS-1:0];
            dsr_next = req.divisor;
            quo_next = '0;
            cnt_next = STEP_W'(PAL_BITS);
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? W_W'(trial - {1'b0, dsr_reg}) : trial[W_W-1:0];
            low_next  = {low_reg[PAL_BITS-2:0], 1'b0};
            quo_next  = {quo_reg[PAL_BITS-2:0], fits};
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/core/crpg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpg_seq
// Sequencer: stores control points, walks the segments for each emit and
// drives the shared divider for segment entry counts and channel blends.
// ----------------------------------------------------------------------------
module crpg_seq
    import crpg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [X_W-1:0]   area_width,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_cmd,
    input  logic             in_first,
    input  point_t           in_point,
    output ptab_wr_t         tab_wr,
    output logic [IDX_W-1:0] tab_addr_a,
    output logic [IDX_W-1:0] tab_addr_b,
    input  point_t           tab_data_a,
    input  point_t           tab_data_b,
    output div_req_t         div_req,
    input  div_rsp_t         div_rsp,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG_RD,
        ST_SEG_EVAL,
        ST_NDIV,
        ST_W1,
        ST_W0,
        ST_MUL0,
        ST_MUL1,
        ST_CDIV_GO,
        ST_CDIV,
        ST_FILL_RD,
        ST_FILL_CAP,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PAL_BITS-1:0]  emit_reg,  emit_next;
    logic [IDX_W-1:0]     k_reg,     k_next;
    logic [PAL_BITS-1:0]  remain_reg, remain_next;
    logic [X_W-1:0]       dist_reg,  dist_next;
    logic [W_W-1:0]       w1_reg,    w1_next;
    logic [W_W-1:0]       w0_reg,    w0_next;
    logic [ACC_W-1:0]     acc_reg,   acc_next;
    logic [CH_IDX_W-1:0]  ch_reg,    ch_next;
    rgba_t                rgba_reg,  rgba_next;
    logic                 empty_reg, empty_next;

    logic [X_W-1:0]   aw_eff;
    logic [X_W-1:0]   dist_cur;
    logic [W_W-1:0]   den;
    logic [CNT_W-1:0] wr_idx;
    logic             at_last_seg;
    logic [CH_W-1:0]  c0;
    logic [CH_W-1:0]  c1;

    // A zero width behaves as one.
    assign aw_eff   = (area_width == '0) ? X_W'(1) : area_width;
    assign dist_cur = (tab_data_b.x > tab_data_a.x) ? X_W'(tab_data_b.x - tab_data_a.x) : '0;
    assign den      = {dist_reg, {PAL_BITS{1'b0}}};
    assign wr_idx   = in_first ? '0 : count_reg;
    assign at_last_seg = ((CNT_W'(k_reg) + CNT_W'(2)) >= count_reg);
    assign c0 = tab_data_a.color[ch_reg];
    assign c1 = tab_data_b.color[ch_reg];

    assign tab_addr_a = k_reg;
    assign tab_addr_b = (state_reg == ST_FILL_RD) ?
                        IDX_W'(count_reg - CNT_W'(1)) : IDX_W'(k_reg + IDX_W'(1));

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        tab_wr.we    = in_valid && in_ready && (in_cmd == CMD_LOAD) &&
                       (wr_idx < CNT_W'(MAX_POINTS));
        tab_wr.addr  = wr_idx[IDX_W-1:0];
        tab_wr.point = in_point;
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {{(ACC_W-W_W){1'b0}}, dist_cur, {PAL_BITS{1'b0}}};
        div_req.divisor  = W_W'(aw_eff);
        if (state_reg == ST_SEG_EVAL) begin
            div_req.start = (dist_cur != '0) && (dist_cur < aw_eff);
        end else if (state_reg == ST_CDIV_GO) begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_reg;
            div_req.divisor  = den;
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        emit_next   = emit_reg;
        k_next      = k_reg;
        remain_next = remain_reg;
        dist_next   = dist_reg;
        w1_next     = w1_reg;
        w0_next     = w0_reg;
        acc_next    = acc_reg;
        ch_next     = ch_reg;
        rgba_next   = rgba_reg;
        empty_next  = empty_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_cmd == CMD_LOAD) begin
                        if (in_first) begin
                            emit_next = '0;
                        end
                        if (wr_idx < CNT_W'(MAX_POINTS)) begin
                            count_next = wr_idx + CNT_W'(1);
                        end else begin
                            count_next = wr_idx;
                        end
                    end else begin
                        remain_next = emit_reg;
                        k_next      = '0;
                        empty_next  = (count_reg == '0);
                        if (count_reg == '0) begin
                            rgba_next  = '0;
                            state_next = ST_DONE;
                        end else if (count_reg == CNT_W'(1)) begin
                            state_next = ST_FILL_RD;
                        end else begin
                            state_next = ST_SEG_RD;
                        end
                    end
                end
            end
            ST_SEG_RD: begin
                state_next = ST_SEG_EVAL;
            end
            ST_SEG_EVAL: begin
                dist_next = dist_cur;
                if (dist_cur >= aw_eff) begin
                    // At least PAL_ENTRIES entries: the index lies here.
                    state_next = ST_W1;
                end else if (dist_cur != '0) begin
                    state_next = ST_NDIV;
                end else if (at_last_seg) begin
                    state_next = ST_FILL_RD;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_SEG_RD;
                end
            end
            ST_NDIV: begin
                if (div_rsp.done) begin
                    if (remain_reg < div_rsp.quotient) begin
                        state_next = ST_W1;
                    end else begin
                        remain_next = remain_reg - div_rsp.quotient;
                        if (at_last_seg) begin
                            state_next = ST_FILL_RD;
                        end else begin
                            k_next     = k_reg + IDX_W'(1);
                            state_next = ST_SEG_RD;
                        end
                    end
                end
            end
            ST_W1: begin
                w1_next    = W_W'(remain_reg) * W_W'(aw_eff);
                ch_next    = '0;
                state_next = ST_W0;
            end
            ST_W0: begin
                w0_next    = den - w1_reg;
                state_next = ST_MUL0;
            end
            ST_MUL0: begin
                acc_next   = ACC_W'(c0) * ACC_W'(w0_reg);
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                acc_next   = acc_reg + ACC_W'(c1) * ACC_W'(w1_reg);
                state_next = ST_CDIV_GO;
            end
            ST_CDIV_GO: begin
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                if (div_rsp.done) begin
                    rgba_next[ch_reg] = div_rsp.quotient;
                    if (ch_reg == CH_IDX_W'(NUM_CH - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        ch_next    = ch_reg + CH_IDX_W'(1);
                        state_next = ST_MUL0;
                    end
                end
            end
            ST_FILL_RD: begin
                state_next = ST_FILL_CAP;
            end
            ST_FILL_CAP: begin
                rgba_next  = tab_data_b.color;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    emit_next  = emit_reg + PAL_BITS'(1);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            emit_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            emit_reg  <= emit_next;
        end
        k_reg      <= k_next;
        remain_reg <= remain_next;
        dist_reg   <= dist_next;
        w1_reg     <= w1_next;
        w0_reg     <= w0_next;
        acc_reg    <= acc_next;
        ch_reg     <= ch_next;
        rgba_reg   <= rgba_next;
        empty_reg  <= empty_next;
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res.index = emit_reg;
    assign res.rgba  = rgba_reg;
    assign res.last  = (emit_reg == PAL_BITS'(PAL_ENTRIES - 1));
    assign res.empty = empty_reg;

endmodule

// File: rtl/core/color_ramp_palette_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_ramp_palette_generator
// Piecewise-linear RGBA color ramp: control points in, palette entries out.
// ----------------------------------------------------------------------------
// The host loads up to sixteen control points through the slave stream with
// tuser[0] low (tuser[1] high restarts the table and the palette index) and
// requests palette entries with tuser[0] high. Each request yields one
// transfer on the master stream carrying the entry index and its RGBA color;
// tlast marks entry 255, after which the index wraps to 0. tuser on the
// master side flags an empty table, in which case the color is zero.
// A load leaves the input ready for the next transfer. A request walks the
// segments one at a time: a segment of zero length or one spanning the
// whole palette needs no division, any other needs the shared divider to
// find its entry count. The blend then runs the same divider once per
// channel, one quotient bit per cycle, while a fill entry past the last
// segment takes the last point's color. A request keeps the input busy
// until its result is handed off to the output register, and m_tvalid
// rises in the cycle after the hand-off. The area_width register is written
// over its own valid/ready channel, which is always ready. After reset the
// table is empty, the palette index is 0 and area_width is 256. The result
// sits in an output register; if the receiver stalls, the block still takes
// the next load or request and holds a second result internally until the
// register frees.
// ----------------------------------------------------------------------------
module color_ramp_palette_generator
    import crpg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Slave stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: point_x, in_red, in_green, in_blue, in_alpha (lowest bit up).
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: cmd, first_point (lowest bit up).
    input  logic [S_TUSER_W-1:0] s_tuser,
    // Master stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: entry_index, out_red, out_green, out_blue, out_alpha.
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    // tuser: table_empty.
    output logic                 m_tuser,
    // Configuration write channel for area_width.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [X_W-1:0]       cfg_data
);

    logic [X_W-1:0] area_width_reg, area_width_next;

    logic     out_valid_reg, out_valid_next;
    res_t     out_reg, out_next;

    point_t   in_point;
    ptab_wr_t tab_wr;
    logic [IDX_W-1:0] tab_addr_a;
    logic [IDX_W-1:0] tab_addr_b;
    point_t   tab_data_a;
    point_t   tab_data_b;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     res_valid;
    logic     res_ready;
    res_t     res;

    assign in_point.x     = s_tdata[X_W-1:0];
    assign in_point.color = s_tdata[X_W+COLOR_W-1:X_W];

    // The configuration register takes every transfer at once.
    assign cfg_ready       = 1'b1;
    assign area_width_next = cfg_valid ? cfg_data : area_width_reg;

    // The output register frees when empty or when its transfer completes.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_width_reg <= X_W'(PAL_ENTRIES);
            out_valid_reg  <= 1'b0;
        end else begin
            area_width_reg <= area_width_next;
            out_valid_reg  <= out_valid_next;
        end
        out_reg <= out_next;
    end

    crpg_ptab u_ptab (
        .aclk      (aclk),
        .wr        (tab_wr),
        .rd_addr_a (tab_addr_a),
        .rd_addr_b (tab_addr_b),
        .rd_data_a (tab_data_a),
        .rd_data_b (tab_data_b)
    );

    crpg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    crpg_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .area_width (area_width_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser[0]),
        .in_first   (s_tuser[1]),
        .in_point   (in_point),
        .tab_wr     (tab_wr),
        .tab_addr_a (tab_addr_a),
        .tab_addr_b (tab_addr_b),
        .tab_data_a (tab_data_a),
        .tab_data_b (tab_data_b),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.rgba, out_reg.index});
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.empty;

    // An empty table always gives a black, transparent entry.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (out_reg.rgba == '0))
        else $error("empty-table entry carries a nonzero color");

    // tlast tracks the final palette index.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (out_reg.index == PAL_BITS'(PAL_ENTRIES - 1))))
        else $error("tlast does not match the final palette index");

    // A request keeps the block busy for at least the next cycle.
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == CMD_EMIT) |=> !s_tready)
        else $error("block ready right after taking a request");

    // A divider start is never repeated straight away.
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> !div_req.start)
        else $error("divider started on two cycles in a row");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the color ramp palette generator.
// ----------------------------------------------------------------------------
// A short table of directed transfers comes first. It covers the empty table,
// a single point, a zero-length segment, a fill entry and the extreme and
// zero ramp widths. Random phases follow, one for each area_width setting.
// Most of their traffic is well-formed ramps: a first point, more points in
// rising x, then a run of palette requests. The rest is noise. A local model
// of the palette math predicts every entry not typed in by a directed row;
// each result is checked field by field against the oldest expected entry.
// ----------------------------------------------------------------------------
module tb_top;
    import crpg_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 50;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PT_W          = $bits(point_t);

    typedef enum logic [1:0] {ROW_LOAD, ROW_EMIT, ROW_CFG} row_kind_t;

    // One directed row. On a typed request row, color is the expected entry.
    // On a configuration row, x carries the new area_width.
    typedef struct packed {
        row_kind_t             kind;
        logic                  first;
        logic [X_W-1:0]        x;
        rgba_t                 color;
        logic                  typed;
        logic [PAL_BITS-1:0]   index;
        logic                  last;
        logic                  empty;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [X_W-1:0]       cfg_data;

    // Local copy of the block's state, kept in step with accepted transfers.
    logic [X_W-1:0] cp_x [MAX_POINTS];
    rgba_t          cp_color [MAX_POINTS];
    int             cp_count;
    int             next_index;
    logic [X_W-1:0] ramp_width;

    res_t      pending_entries[$];
    stim_row_t directed_rows[$];
    int        mismatch_count;
    int        cycle_count;
    int        src_idle_pct;
    int        sink_idle_pct;

    color_ramp_palette_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The receiver stalls at random. Its ready is set at the clock edge like
    // every other input.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // A load clears the table and the palette index when first is set, then
    // appends the point unless the table is already full.
    function automatic void store_control_point(logic first, point_t pt);
        if (first) begin
            cp_count   = 0;
            next_index = 0;
        end
        if (cp_count < MAX_POINTS) begin
            cp_x[cp_count]     = pt.x;
            cp_color[cp_count] = pt.color;
            cp_count++;
        end
    endfunction

    // Works out the palette entry at next_index and moves the index on.
    // Segments are walked in order. Each one owns floor(len*256/width)
    // entries. Within a segment the channels blend linearly and truncate.
    // Past the last segment an entry takes the last point's color.
    function automatic res_t predict_palette_entry();
        res_t            r;
        longint unsigned width, remaining, seg_len, n, den, w0, w1, c0, c1;
        int              k, c;
        bit              found;
        r       = '0;
        r.index = next_index[PAL_BITS-1:0];
        r.last  = (next_index >= PAL_ENTRIES - 1);
        r.empty = (cp_count == 0);
        width   = (ramp_width == 0) ? 64'd1 : 64'(ramp_width);
        if (cp_count != 0) begin
            remaining = 64'(next_index);
            found     = 1'b0;
            for (k = 0; k + 1 < cp_count; k++) begin
                seg_len = (cp_x[k+1] > cp_x[k]) ? 64'(cp_x[k+1] - cp_x[k]) : 64'd0;
                n       = seg_len * 64'(PAL_ENTRIES) / width;
                if (remaining < n) begin
                    den = 64'(PAL_ENTRIES) * seg_len;
                    w1  = remaining * width;
                    w0  = den - w1;
                    for (c = 0; c < NUM_CH; c++) begin
                        c0 = 64'(cp_color[k][c]);
                        c1 = 64'(cp_color[k+1][c]);
                        r.rgba[c] = CH_W'((c0 * w0 + c1 * w1) / den);
                    end
                    found = 1'b1;
                    break;
                end
                remaining -= n;
            end
            if (!found) begin
                r.rgba = cp_color[cp_count-1];
            end
        end
        next_index = (next_index >= PAL_ENTRIES - 1) ? 0 : next_index + 1;
        return r;
    endfunction

    // Offers one transfer on the input stream and updates the local state once
    // it is taken. Valid only drops when the sender decides to idle, so a
    // back-to-back transfer never lowers and raises it in the same step.
    task automatic send_item(logic cmd, logic first, point_t pt, logic typed, res_t want);
        res_t predicted;
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(pt);
        s_tuser  <= {first, cmd};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_LOAD) begin
            store_control_point(first, pt);
        end else begin
            // The local index moves on even when the expected entry is typed in.
            predicted = predict_palette_entry();
            pending_entries.push_back(typed ? want : predicted);
        end
    endtask

    // Stops sending and waits until every predicted entry has come back, then
    // lets a trailing load finish inside the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_ramp_width(logic [X_W-1:0] width);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= width;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        ramp_width = width;
    endtask

    function automatic void add_row(row_kind_t kind, logic first, logic [X_W-1:0] x,
                                    rgba_t color, logic typed, int index,
                                    logic last, logic empty);
        stim_row_t r;
        r.kind  = kind;
        r.first = first;
        r.x     = x;
        r.color = color;
        r.typed = typed;
        r.index = index[PAL_BITS-1:0];
        r.last  = last;
        r.empty = empty;
        directed_rows.push_back(r);
    endfunction

    // One random frame. A well-formed ramp loads its points in rising x,
    // sometimes past a full table or with scrambled x, then requests entries,
    // now and then slipping in an appended point. An exact frame makes one
    // segment of 255 entries, so that entry 255 is a fill entry, and requests
    // at least up to entry 255. Noise is any mix of loads and requests.
    task automatic play_ramp_frame(bit exact, output int sent);
        int             kind, npts, nemit, i, step;
        bit             scrambled;
        logic [X_W-1:0] xpos;
        point_t         pt;
        sent = 0;
        kind = $urandom_range(99);
        if (exact || (kind < 10 && ramp_width == PAL_ENTRIES)) begin
            pt.x     = X_W'($urandom_range(768));
            pt.color = $urandom;
            send_item(CMD_LOAD, 1'b1, pt, 1'b0, '0);
            pt.x     = pt.x + X_W'(255);
            pt.color = $urandom;
            send_item(CMD_LOAD, 1'b0, pt, 1'b0, '0);
            nemit = $urandom_range(300, 256);
            for (i = 0; i < nemit; i++) begin
                pt = PT_W'({$urandom, $urandom});
                send_item(CMD_EMIT, 1'($urandom_range(1)), pt, 1'b0, '0);
            end
            sent = nemit + 2;
        end else if (kind < 85) begin
            npts      = ($urandom_range(9) == 0) ? $urandom_range(MAX_POINTS + 3, 7)
                                                 : $urandom_range(6, 1);
            scrambled = ($urandom_range(9) == 0);
            xpos      = X_W'($urandom_range(600));
            for (i = 0; i < npts; i++) begin
                pt.x     = xpos;
                pt.color = $urandom;
                send_item(CMD_LOAD, i == 0, pt, 1'b0, '0);
                step = $urandom_range(300);
                if (scrambled) begin
                    xpos = X_W'($urandom_range(1023));
                end else begin
                    xpos = (xpos + step > 1023) ? X_W'(1023) : X_W'(xpos + step);
                end
            end
            nemit = ($urandom_range(9) == 0) ? $urandom_range(300, 256)
                                             : $urandom_range(40, 4);
            for (i = 0; i < nemit; i++) begin
                if ($urandom_range(39) == 0) begin
                    pt.x     = X_W'($urandom_range(1023));
                    pt.color = $urandom;
                    send_item(CMD_LOAD, 1'b0, pt, 1'b0, '0);
                    sent++;
                end
                pt = PT_W'({$urandom, $urandom});
                send_item(CMD_EMIT, 1'($urandom_range(1)), pt, 1'b0, '0);
            end
            sent += npts + nemit;
        end else begin
            nemit = $urandom_range(8, 1);
            for (i = 0; i < nemit; i++) begin
                pt = PT_W'({$urandom, $urandom});
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)), pt, 1'b0, '0);
            end
            sent = nemit;
        end
    endtask

    // Result checker: every transfer taken on the output stream must match
    // the oldest prediction in every field.
    always @(posedge aclk) begin
        res_t  got;
        res_t  want;
        string ch_name [NUM_CH];
        ch_name = '{"red", "green", "blue", "alpha"};
        if (aresetn && m_tvalid && m_tready) begin
            got.index = m_tdata[PAL_BITS-1:0];
            got.rgba  = m_tdata[PAL_BITS +: COLOR_W];
            got.last  = m_tlast;
            got.empty = m_tuser;
            if (pending_entries.size() == 0) begin
                report_mismatch("result with none expected, index", got.index, 0);
            end else begin
                want = pending_entries.pop_front();
                if (got.index != want.index) begin
                    report_mismatch("entry_index", got.index, want.index);
                end
                for (int c = 0; c < NUM_CH; c++) begin
                    if (got.rgba[c] != want.rgba[c]) begin
                        report_mismatch(ch_name[c], got.rgba[c], want.rgba[c]);
                    end
                end
                if (got.last != want.last) begin
                    report_mismatch("last_entry", got.last, want.last);
                end
                if (got.empty != want.empty) begin
                    report_mismatch("table_empty", got.empty, want.empty);
                end
            end
        end
    end

    initial begin
        stim_row_t      r;
        point_t         pt;
        res_t           want;
        int             sent, phase_sent;
        logic [X_W-1:0] phase_width [7];

        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        cycle_count    = 0;
        mismatch_count = 0;
        cp_count       = 0;
        next_index     = 0;
        ramp_width     = 10'd256;
        src_idle_pct   = 25;
        sink_idle_pct  = 25;

        // Requests on an empty table, then a single point at the top of x.
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b1, 0, 1'b0, 1'b1);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b1, 1, 1'b0, 1'b1);
        add_row(ROW_LOAD, 1'b1, 10'd1023, 32'hFFFF_FFFF, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'hFFFF_FFFF, 1'b1, 0, 1'b0, 1'b0);
        // A point at x 0 after x 1023 makes a segment that does not increase,
        // so every entry is a fill with the last point's color.
        add_row(ROW_LOAD, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b1, 1, 1'b0, 1'b0);
        // A four-entry segment, a zero-length one after it, then a fill.
        add_row(ROW_LOAD, 1'b1, 10'd0,    32'h00FF_00FF, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_LOAD, 1'b0, 10'd4,    32'hFF00_FF00, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h00FF_00FF, 1'b1, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_LOAD, 1'b0, 10'd4,    32'h1234_5678, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h1234_5678, 1'b1, 4, 1'b0, 1'b0);
        // A zero width acts as one.
        add_row(ROW_CFG,  1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        // Widest ramp: one segment over the whole x range.
        add_row(ROW_CFG,  1'b0, 10'd1023, 32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_LOAD, 1'b1, 10'd0,    32'h8080_8080, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_LOAD, 1'b0, 10'd1023, 32'h7F7F_7F7F, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h8080_8080, 1'b1, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_CFG,  1'b0, 10'd1,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);
        add_row(ROW_EMIT, 1'b0, 10'd0,    32'h0000_0000, 1'b0, 0, 1'b0, 1'b0);

        phase_width = '{10'd256, 10'd1, 10'd1023, 10'($urandom_range(1022, 2)),
                        10'($urandom_range(1022, 2)), 10'd512, 10'd256};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            case (r.kind)
                ROW_CFG: begin
                    write_ramp_width(r.x);
                end
                ROW_LOAD: begin
                    pt.x     = r.x;
                    pt.color = r.color;
                    send_item(CMD_LOAD, r.first, pt, 1'b0, '0);
                end
                default: begin
                    want.index = r.index;
                    want.rgba  = r.color;
                    want.last  = r.last;
                    want.empty = r.empty;
                    send_item(CMD_EMIT, 1'b0, '0, r.typed, want);
                end
            endcase
        end

        // Random phases, one per ramp width. The third one runs with neither
        // side idling at all.
        foreach (phase_width[p]) begin
            write_ramp_width(phase_width[p]);
            src_idle_pct  = (p == 2) ? 0 : 25;
            sink_idle_pct = (p == 2) ? 0 : 25;
            phase_sent    = 0;
            while (phase_sent < PHASE_ITEMS) begin
                play_ramp_frame(p == 0 && phase_sent == 0, sent);
                phase_sent += sent;
                // Now and then hold off until the block has caught up.
                if ($urandom_range(7) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (pending_entries.size() != 0) begin
            report_mismatch("entries never produced", 0, pending_entries.size());
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
